FILE: design/radial_gradient_color_blend_unit_macros.svh
// ----------------------------------------------------------------------------
// Radial gradient color blend: assertion macros
// Shared concurrent assertion forms. Defining ASSERT_OFF removes them all.
// ----------------------------------------------------------------------------
`ifndef RADIAL_GRADIENT_COLOR_BLEND_UNIT_MACROS_SVH
`define RADIAL_GRADIENT_COLOR_BLEND_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, sampled on the rising clock edge.
`define RGCB_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");
// Next-cycle implication, sampled on the rising clock edge.
`define RGCB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define RGCB_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define RGCB_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: design/rgcb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radial gradient color blend package
// Widths, register indexes and payload types shared by the block's modules.
// ----------------------------------------------------------------------------
package rgcb_pkg;

    localparam int COORD_WIDTH_DEF = 24;
    localparam int CHANNEL_BITS    = 8;
    localparam int NUM_CHAN        = 3;
    localparam int NUM_GROUPS      = 3;
    localparam int COLOR_W         = 24;
    localparam int RADIUS_W        = 24;
    localparam int FRAC_BITS       = 16;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 24;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_RADIUS = 3'd0,
        CFG_END_RADIUS   = 3'd1,
        CFG_DIFFUSE      = 3'd2,
        CFG_REFLECT      = 3'd3,
        CFG_TRANSPARENT  = 3'd4,
        CFG_ENABLES      = 3'd5
    } t_cfg_idx;

    // The three incoming colors of one beat.
    typedef struct packed {
        logic [COLOR_W-1:0] diffuse;
        logic [COLOR_W-1:0] reflect;
        logic [COLOR_W-1:0] transp;
    } t_colors;

    // Colors plus the region decision, carried beside the divider.
    typedef struct packed {
        t_colors colors;
        logic    pass;
        logic    full;
    } t_blend_side;

endpackage

FILE: design/radial_gradient_color_blend_unit.sv
`timescale 1ns / 1ps
`include "radial_gradient_color_blend_unit_macros.svh"
// ----------------------------------------------------------------------------
// Radial gradient color blend unit
// Blends three RGB colors toward configured targets by the distance of a hit
// point from the origin, between an inner and an outer radius.
// ----------------------------------------------------------------------------
// The unit takes one hit beat per clock while the output buffer has room and
// returns one result beat per hit, in order. Most of the pipeline depth lies
// in the square root, which resolves one distance bit per stage, and in the
// weight divider, which resolves one of its 16 bits per stage. A two-entry
// output buffer keeps full rate across output stalls. Configuration writes
// are taken at any time but should be made only while no hit is in flight.
// ----------------------------------------------------------------------------
module radial_gradient_color_blend_unit
    import rgcb_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Hit input channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic signed [COORD_WIDTH-1:0] i_pos_x,
    input  logic signed [COORD_WIDTH-1:0] i_pos_y,
    input  logic signed [COORD_WIDTH-1:0] i_pos_z,
    input  logic [COLOR_W-1:0]            i_in_diffuse,
    input  logic [COLOR_W-1:0]            i_in_reflect,
    input  logic [COLOR_W-1:0]            i_in_transparent,
    // Result channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [COLOR_W-1:0]            o_out_diffuse,
    output logic [COLOR_W-1:0]            o_out_reflect,
    output logic [COLOR_W-1:0]            o_out_transparent,
    // Configuration write channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [CFG_DATA_W-1:0]         i_cfg_data
);

    localparam int SQ_W    = 2 * COORD_WIDTH;
    localparam int CMP_W   = (COORD_WIDTH > RADIUS_W) ? COORD_WIDTH : RADIUS_W;
    localparam int PT_W    = CHANNEL_BITS + FRAC_BITS;
    localparam int PC_W    = CHANNEL_BITS + FRAC_BITS + 1;
    localparam int SUM_W   = PC_W + 1;
    localparam int COL_W   = $bits(t_colors);
    localparam int BSIDE_W = $bits(t_blend_side);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [RADIUS_W-1:0]   r_start;
    logic [RADIUS_W-1:0]   r_end;
    logic [COLOR_W-1:0]    r_tgt [NUM_GROUPS];
    logic [NUM_GROUPS-1:0] r_enables;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start   <= '0;
            r_end     <= RADIUS_W'(1 << FRAC_BITS);
            r_tgt[0]  <= '0;
            r_tgt[1]  <= '0;
            r_tgt[2]  <= '0;
            r_enables <= NUM_GROUPS'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_START_RADIUS: r_start   <= i_cfg_data[RADIUS_W-1:0];
                CFG_END_RADIUS:   r_end     <= i_cfg_data[RADIUS_W-1:0];
                CFG_DIFFUSE:      r_tgt[0]  <= i_cfg_data[COLOR_W-1:0];
                CFG_REFLECT:      r_tgt[1]  <= i_cfg_data[COLOR_W-1:0];
                CFG_TRANSPARENT:  r_tgt[2]  <= i_cfg_data[COLOR_W-1:0];
                CFG_ENABLES:      r_enables <= i_cfg_data[NUM_GROUPS-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline advance: every stage moves while the output buffer has room.
    // ------------------------------------------------------------------
    logic r_skid_valid;
    logic en;

    assign en         = !r_skid_valid;
    assign o_in_ready = en;

    // ------------------------------------------------------------------
    // Stage 1: coordinate magnitudes.
    // ------------------------------------------------------------------
    logic                   r_s1_v;
    logic [COORD_WIDTH-1:0] r_s1_mag [3];
    t_colors                r_s1_col;
    logic [COORD_WIDTH-1:0] mag_x, mag_y, mag_z;

    assign mag_x = i_pos_x[COORD_WIDTH-1] ? (~i_pos_x + 1'b1) : i_pos_x;
    assign mag_y = i_pos_y[COORD_WIDTH-1] ? (~i_pos_y + 1'b1) : i_pos_y;
    assign mag_z = i_pos_z[COORD_WIDTH-1] ? (~i_pos_z + 1'b1) : i_pos_z;

    // ------------------------------------------------------------------
    // Stage 2: squares.  Stage 3: sum of squares.
    // ------------------------------------------------------------------
    logic            r_s2_v;
    logic [SQ_W-1:0] r_s2_sq [3];
    t_colors         r_s2_col;
    logic            r_s3_v;
    logic [SQ_W-1:0] r_s3_sum;
    t_colors         r_s3_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
        end else if (en) begin
            r_s1_v <= i_in_valid;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_mag[0] <= mag_x;
            r_s1_mag[1] <= mag_y;
            r_s1_mag[2] <= mag_z;
            r_s1_col    <= '{diffuse: i_in_diffuse, reflect: i_in_reflect,
                             transp: i_in_transparent};
            r_s2_sq[0]  <= SQ_W'(r_s1_mag[0]) * SQ_W'(r_s1_mag[0]);
            r_s2_sq[1]  <= SQ_W'(r_s1_mag[1]) * SQ_W'(r_s1_mag[1]);
            r_s2_sq[2]  <= SQ_W'(r_s1_mag[2]) * SQ_W'(r_s1_mag[2]);
            r_s2_col    <= r_s1_col;
            // Three squares of at most 2^(2W-2) each cannot overflow 2W bits.
            r_s3_sum    <= r_s2_sq[0] + r_s2_sq[1] + r_s2_sq[2];
            r_s3_col    <= r_s2_col;
        end
    end

    // ------------------------------------------------------------------
    // Distance from the sum of squares.
    // ------------------------------------------------------------------
    logic                   sq_v;
    logic [COORD_WIDTH-1:0] sq_dist;
    logic [COL_W-1:0]       sq_side;

    rgcb_sqrt #(
        .ROOT_W (COORD_WIDTH),
        .SIDE_W (COL_W)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s3_v),
        .i_rad   (r_s3_sum),
        .i_side  (r_s3_col),
        .o_valid (sq_v),
        .o_root  (sq_dist),
        .o_side  (sq_side)
    );

    // ------------------------------------------------------------------
    // Stage 4: region decision and divider operands.
    // ------------------------------------------------------------------
    logic                r_s4_v;
    logic [RADIUS_W-1:0] r_s4_num;
    logic [RADIUS_W-1:0] r_s4_den;
    t_blend_side         r_s4_side;
    logic [CMP_W-1:0]    dist_e, start_e, end_e, dist_gap, span;
    logic                c_pass, c_full;

    always_comb begin
        dist_e   = CMP_W'(sq_dist);
        start_e  = CMP_W'(r_start);
        end_e    = CMP_W'(r_end);
        dist_gap = end_e - dist_e;
        span     = end_e - start_e;
        c_pass   = dist_e <= start_e;
        c_full   = !c_pass && (dist_e >= end_e);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_v <= 1'b0;
        end else if (en) begin
            r_s4_v <= sq_v;
        end
    end

    // Outside the blend band the divider gets a harmless zero over one.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s4_num         <= (c_pass || c_full) ? '0 : dist_gap[RADIUS_W-1:0];
            r_s4_den         <= (c_pass || c_full) ? RADIUS_W'(1) : span[RADIUS_W-1:0];
            r_s4_side.colors <= t_colors'(sq_side);
            r_s4_side.pass   <= c_pass;
            r_s4_side.full   <= c_full;
        end
    end

    // ------------------------------------------------------------------
    // Blend weight.
    // ------------------------------------------------------------------
    logic                 dv_v;
    logic [FRAC_BITS-1:0] dv_w;
    logic [BSIDE_W-1:0]   dv_side;

    rgcb_div #(
        .QUOT_W (FRAC_BITS),
        .DEN_W  (RADIUS_W),
        .SIDE_W (BSIDE_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s4_v),
        .i_num   (r_s4_num),
        .i_den   (r_s4_den),
        .i_side  (r_s4_side),
        .o_valid (dv_v),
        .o_quot  (dv_w),
        .o_side  (dv_side)
    );

    // ------------------------------------------------------------------
    // Stage 5: per-channel products of target and weight, and of input and the weight's complement.
    // ------------------------------------------------------------------
    t_blend_side          dv_bs;
    logic [FRAC_BITS:0]   inv_w;
    logic [COLOR_W-1:0]   dv_in [NUM_GROUPS];
    logic                 r_s5_v;
    t_blend_side          r_s5_side;
    logic [PT_W-1:0]      r_s5_pt [NUM_GROUPS][NUM_CHAN];
    logic [PC_W-1:0]      r_s5_pc [NUM_GROUPS][NUM_CHAN];

    assign dv_bs    = t_blend_side'(dv_side);
    assign inv_w    = {1'b1, {FRAC_BITS{1'b0}}} - {1'b0, dv_w};
    assign dv_in[0] = dv_bs.colors.diffuse;
    assign dv_in[1] = dv_bs.colors.reflect;
    assign dv_in[2] = dv_bs.colors.transp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_v <= 1'b0;
        end else if (en) begin
            r_s5_v <= dv_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s5_side <= dv_bs;
            for (int g = 0; g < NUM_GROUPS; g++) begin
                for (int c = 0; c < NUM_CHAN; c++) begin
                    r_s5_pt[g][c] <= PT_W'(r_tgt[g][c*CHANNEL_BITS +: CHANNEL_BITS]) *
                                     PT_W'(dv_w);
                    r_s5_pc[g][c] <= PC_W'(dv_in[g][c*CHANNEL_BITS +: CHANNEL_BITS]) *
                                     PC_W'(inv_w);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: sum, scale down and select per group.
    // ------------------------------------------------------------------
    logic               r_s6_v;
    t_colors            r_s6_out;
    logic [COLOR_W-1:0] s5_in  [NUM_GROUPS];
    logic [COLOR_W-1:0] s6_res [NUM_GROUPS];
    logic [SUM_W-1:0]   ch_sum;

    assign s5_in[0] = r_s5_side.colors.diffuse;
    assign s5_in[1] = r_s5_side.colors.reflect;
    assign s5_in[2] = r_s5_side.colors.transp;

    always_comb begin
        ch_sum = '0;
        for (int g = 0; g < NUM_GROUPS; g++) begin
            s6_res[g] = s5_in[g];
            if (r_enables[g] && !r_s5_side.pass) begin
                if (r_s5_side.full) begin
                    s6_res[g] = r_tgt[g];
                end else begin
                    for (int c = 0; c < NUM_CHAN; c++) begin
                        ch_sum = SUM_W'(r_s5_pt[g][c]) + SUM_W'(r_s5_pc[g][c]);
                        s6_res[g][c*CHANNEL_BITS +: CHANNEL_BITS] =
                            ch_sum[FRAC_BITS +: CHANNEL_BITS];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s6_v <= 1'b0;
        end else if (en) begin
            r_s6_v <= r_s5_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s6_out <= '{diffuse: s6_res[0], reflect: s6_res[1], transp: s6_res[2]};
        end
    end

    // ------------------------------------------------------------------
    // Output register with a skid entry behind it.
    // ------------------------------------------------------------------
    logic    r_out_valid;
    t_colors r_out;
    t_colors r_skid;
    logic    n_out_valid, n_skid_valid;
    t_colors n_out, n_skid;
    logic    out_free, push;

    assign out_free = !r_out_valid || i_out_ready;
    assign push     = en && r_s6_v;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        n_skid_valid = r_skid_valid;
        n_skid       = r_skid;
        if (out_free) begin
            if (r_skid_valid) begin
                n_out_valid  = 1'b1;
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end else if (push) begin
                n_out_valid = 1'b1;
                n_out       = r_s6_out;
            end else begin
                n_out_valid = 1'b0;
            end
        end else if (push) begin
            n_skid_valid = 1'b1;
            n_skid       = r_s6_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_out_valid       = r_out_valid;
    assign o_out_diffuse     = r_out.diffuse;
    assign o_out_reflect     = r_out.reflect;
    assign o_out_transparent = r_out.transp;

    // The skid entry only ever holds a beat behind a waiting output beat.
    `RGCB_ASSERT_IMPL(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid)
    // The skid entry fills only when the output beat was stalled.
    `RGCB_ASSERT_IMPL(a_skid_fill_on_stall, i_clk, i_rst_n, $rose(r_skid_valid), $past(r_out_valid && !i_out_ready))
    // A stalled output keeps the skid beat in place.
    `RGCB_ASSERT_NEXT(a_skid_holds, i_clk, i_rst_n, r_skid_valid && !i_out_ready, r_skid_valid)
    // Pass and full replacement never both apply to one beat.
    `RGCB_ASSERT_IMPL(a_region_exclusive, i_clk, i_rst_n, r_s4_v && r_s4_side.pass, !r_s4_side.full)

endmodule

FILE: design/rgcb_sqrt.sv
`timescale 1ns / 1ps
`include "radial_gradient_color_blend_unit_macros.svh"
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Digit-by-digit restoring square root, one root bit per register stage, with
// a sideband word that travels alongside each beat.
// ----------------------------------------------------------------------------
module rgcb_sqrt
    import rgcb_pkg::*;
#(
    parameter int ROOT_W = COORD_WIDTH_DEF,
    parameter int SIDE_W = 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [2*ROOT_W-1:0]   i_rad,
    input  logic [SIDE_W-1:0]     i_side,
    output logic                  o_valid,
    output logic [ROOT_W-1:0]     o_root,
    output logic [SIDE_W-1:0]     o_side
);

    localparam int RAD_W = 2 * ROOT_W;
    localparam int REM_W = ROOT_W + 3;

    logic              r_v    [ROOT_W];
    logic [RAD_W-1:0]  r_rad  [ROOT_W];
    logic [REM_W-1:0]  r_rem  [ROOT_W];
    logic [ROOT_W-1:0] r_root [ROOT_W];
    logic [SIDE_W-1:0] r_side [ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        logic              c_v;
        logic [RAD_W-1:0]  c_rad;
        logic [REM_W-1:0]  c_rem;
        logic [ROOT_W-1:0] c_root;
        logic [SIDE_W-1:0] c_side;
        logic [REM_W-1:0]  sh_rem;
        logic [REM_W-1:0]  trial;
        logic [REM_W-1:0]  n_rem;
        logic [ROOT_W-1:0] n_root;

        // Stage input comes from the ports or from the previous stage.
        if (k == 0) begin : g_first
            assign c_v    = i_valid;
            assign c_rad  = i_rad;
            assign c_rem  = '0;
            assign c_root = '0;
            assign c_side = i_side;
        end else begin : g_next
            assign c_v    = r_v[k-1];
            assign c_rad  = r_rad[k-1];
            assign c_rem  = r_rem[k-1];
            assign c_root = r_root[k-1];
            assign c_side = r_side[k-1];
        end

        // Bring down two radicand bits and try the next root bit.
        always_comb begin
            sh_rem = {c_rem[REM_W-3:0], c_rad[RAD_W-1 -: 2]};
            trial  = {1'b0, c_root, 2'b01};
            if (sh_rem >= trial) begin
                n_rem  = sh_rem - trial;
                n_root = {c_root[ROOT_W-2:0], 1'b1};
            end else begin
                n_rem  = sh_rem;
                n_root = {c_root[ROOT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= c_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad[k]  <= {c_rad[RAD_W-3:0], 2'b00};
                r_rem[k]  <= n_rem;
                r_root[k] <= n_root;
                r_side[k] <= c_side;
            end
        end
    end

    assign o_valid = r_v[ROOT_W-1];
    assign o_root  = r_root[ROOT_W-1];
    assign o_side  = r_side[ROOT_W-1];

    // A finished root leaves a remainder of at most twice the root.
    `RGCB_ASSERT_IMPL(a_root_rem_bound, i_clk, i_rst_n, r_v[ROOT_W-1], r_rem[ROOT_W-1] <= {2'b00, r_root[ROOT_W-1], 1'b0})

endmodule

FILE: design/rgcb_div.sv
`timescale 1ns / 1ps
`include "radial_gradient_color_blend_unit_macros.svh"
// ----------------------------------------------------------------------------
// Pipelined fractional divider
// Restoring division of a numerator below the denominator, one quotient bit
// per register stage, giving floor(num * 2^QUOT_W / den).
// ----------------------------------------------------------------------------
module rgcb_div
    import rgcb_pkg::*;
#(
    parameter int QUOT_W = FRAC_BITS,
    parameter int DEN_W  = RADIUS_W,
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [DEN_W-1:0]  i_num,
    input  logic [DEN_W-1:0]  i_den,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [QUOT_W-1:0] o_quot,
    output logic [SIDE_W-1:0] o_side
);

    logic              r_v    [QUOT_W];
    logic [DEN_W-1:0]  r_rem  [QUOT_W];
    logic [DEN_W-1:0]  r_den  [QUOT_W];
    logic [QUOT_W-1:0] r_quot [QUOT_W];
    logic [SIDE_W-1:0] r_side [QUOT_W];

    for (genvar k = 0; k < QUOT_W; k++) begin : g_stage
        logic              c_v;
        logic [DEN_W-1:0]  c_rem;
        logic [DEN_W-1:0]  c_den;
        logic [QUOT_W-1:0] c_quot;
        logic [SIDE_W-1:0] c_side;
        logic [DEN_W:0]    sh_rem;
        logic [DEN_W:0]    diff;
        logic [DEN_W-1:0]  n_rem;
        logic [QUOT_W-1:0] n_quot;

        if (k == 0) begin : g_first
            assign c_v    = i_valid;
            assign c_rem  = i_num;
            assign c_den  = i_den;
            assign c_quot = '0;
            assign c_side = i_side;
        end else begin : g_next
            assign c_v    = r_v[k-1];
            assign c_rem  = r_rem[k-1];
            assign c_den  = r_den[k-1];
            assign c_quot = r_quot[k-1];
            assign c_side = r_side[k-1];
        end

        // Shift the partial remainder and subtract where the divisor fits.
        always_comb begin
            sh_rem = {c_rem, 1'b0};
            diff   = sh_rem - {1'b0, c_den};
            if (sh_rem >= {1'b0, c_den}) begin
                n_rem  = diff[DEN_W-1:0];
                n_quot = {c_quot[QUOT_W-2:0], 1'b1};
            end else begin
                n_rem  = sh_rem[DEN_W-1:0];
                n_quot = {c_quot[QUOT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= c_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_rem;
                r_den[k]  <= c_den;
                r_quot[k] <= n_quot;
                r_side[k] <= c_side;
            end
        end
    end

    assign o_valid = r_v[QUOT_W-1];
    assign o_quot  = r_quot[QUOT_W-1];
    assign o_side  = r_side[QUOT_W-1];

    // The numerator always enters below the divisor, so the remainder stays there.
    `RGCB_ASSERT_IMPL(a_div_rem_bound, i_clk, i_rst_n, r_v[QUOT_W-1], r_rem[QUOT_W-1] < r_den[QUOT_W-1])

endmodule

FILE: bench/radial_gradient_color_blend_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radial gradient color blend unit testbench
// Drives hit beats with random gaps and random output stalls, predicts each
// blended result from the distance and the radii, and compares in order.
// ----------------------------------------------------------------------------
module radial_gradient_color_blend_unit_tb;
    import rgcb_pkg::*;

    localparam int CW          = 24;
    localparam int LATENCY     = CW + 23;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [COLOR_W-1:0] diffuse;
        logic [COLOR_W-1:0] reflect;
        logic [COLOR_W-1:0] transp;
    } t_result;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic signed [CW-1:0] i_pos_x;
    logic signed [CW-1:0] i_pos_y;
    logic signed [CW-1:0] i_pos_z;
    logic [COLOR_W-1:0]   i_in_diffuse;
    logic [COLOR_W-1:0]   i_in_reflect;
    logic [COLOR_W-1:0]   i_in_transparent;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic [COLOR_W-1:0]   o_out_diffuse;
    logic [COLOR_W-1:0]   o_out_reflect;
    logic [COLOR_W-1:0]   o_out_transparent;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    // Shadow copy of the blend settings.
    logic [23:0] shadow_start;
    logic [23:0] shadow_end;
    logic [23:0] shadow_target [3];
    logic [2:0]  shadow_enables;

    t_result     expected_colors[$];
    int          error_count;
    int          cycle_count;
    int          hold_off_cycles;
    bit          random_stalls;

    radial_gradient_color_blend_unit #(.COORD_WIDTH(CW)) dut (.*);

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Cycle watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Integer square root, rounded down.
    function automatic logic [63:0] floor_sqrt(logic [63:0] v);
        logic [63:0] root;
        logic [63:0] bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= root + bitv) begin
                v    = v - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return root;
    endfunction

    function automatic logic [63:0] magnitude(logic signed [CW-1:0] c);
        logic [CW-1:0] m;
        m = c[CW-1] ? (~c + 1'b1) : c;
        return {40'd0, m};
    endfunction

    // Blends one packed color toward its target with weight w out of 65536.
    function automatic logic [23:0] mix_color(logic [23:0] tgt, logic [23:0] col,
                                              logic [63:0] w);
        logic [23:0] res;
        logic [63:0] r;
        for (int k = 0; k < 3; k++) begin
            r = ({56'd0, tgt[k*8 +: 8]} * w
                 + {56'd0, col[k*8 +: 8]} * (64'd65536 - w)) >> 16;
            res[k*8 +: 8] = r[7:0];
        end
        return res;
    endfunction

    // Expected colors for one hit under the current settings.
    function automatic t_result gradient_colors(logic signed [CW-1:0] x,
                                                logic signed [CW-1:0] y,
                                                logic signed [CW-1:0] z,
                                                logic [23:0] d, logic [23:0] r,
                                                logic [23:0] t);
        logic [63:0] sum;
        logic [63:0] distance;
        logic [63:0] w;
        logic [23:0] cols [3];
        t_result     res;
        sum  = magnitude(x) * magnitude(x) + magnitude(y) * magnitude(y)
               + magnitude(z) * magnitude(z);
        distance = floor_sqrt(sum);
        cols[0] = d;
        cols[1] = r;
        cols[2] = t;
        if (distance > {40'd0, shadow_start}) begin
            if (distance >= {40'd0, shadow_end}) begin
                for (int g = 0; g < 3; g++)
                    if (shadow_enables[g]) cols[g] = shadow_target[g];
            end else begin
                w = (64'd65536 * ({40'd0, shadow_end} - distance))
                    / ({40'd0, shadow_end} - {40'd0, shadow_start});
                for (int g = 0; g < 3; g++)
                    if (shadow_enables[g]) cols[g] = mix_color(shadow_target[g], cols[g], w);
            end
        end
        res.diffuse = cols[0];
        res.reflect = cols[1];
        res.transp  = cols[2];
        return res;
    endfunction

    // Result checker and output stall generator.
    initial begin
        int wait_cycles;
        t_result exp_res;
        i_out_ready = 1'b0;
        wait_cycles = 0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid && i_out_ready) begin
                if (expected_colors.size() == 0) begin
                    $error("unexpected result beat");
                    error_count++;
                end else begin
                    exp_res = expected_colors.pop_front();
                    if (o_out_diffuse !== exp_res.diffuse) begin
                        $error("out_diffuse exp %h got %h", exp_res.diffuse, o_out_diffuse);
                        error_count++;
                    end
                    if (o_out_reflect !== exp_res.reflect) begin
                        $error("out_reflect exp %h got %h", exp_res.reflect, o_out_reflect);
                        error_count++;
                    end
                    if (o_out_transparent !== exp_res.transp) begin
                        $error("out_transparent exp %h got %h", exp_res.transp,
                               o_out_transparent);
                        error_count++;
                    end
                end
                wait_cycles = random_stalls ? $urandom_range(0, 18) : 0;
            end
            @(negedge i_clk);
            if (hold_off_cycles > 0) begin
                hold_off_cycles--;
                i_out_ready <= 1'b0;
            end else if (wait_cycles > 0) begin
                wait_cycles--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Sends one hit beat after an optional gap and records its prediction.
    // Valid stays high on return so that beats can follow back to back; a gap
    // or the drain task takes it low.
    task automatic send_hit(logic signed [CW-1:0] x, logic signed [CW-1:0] y,
                            logic signed [CW-1:0] z, logic [23:0] d,
                            logic [23:0] r, logic [23:0] t, int gap);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_pos_x          <= x;
        i_pos_y          <= y;
        i_pos_z          <= z;
        i_in_diffuse     <= d;
        i_in_reflect     <= r;
        i_in_transparent <= t;
        do @(posedge i_clk); while (!o_in_ready);
        expected_colors.push_back(gradient_colors(x, y, z, d, r, t));
        @(negedge i_clk);
    endtask

    // Waits for every expected beat, then lets the pipeline settle.
    task automatic drain;
        i_in_valid <= 1'b0;
        while (expected_colors.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Writes one register; valid is left high for a following write.
    task automatic write_reg(t_cfg_idx idx, logic [23:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_START_RADIUS: shadow_start = value;
            CFG_END_RADIUS:   shadow_end = value;
            CFG_DIFFUSE:      shadow_target[0] = value;
            CFG_REFLECT:      shadow_target[1] = value;
            CFG_TRANSPARENT:  shadow_target[2] = value;
            CFG_ENABLES:      shadow_enables = value[2:0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic configure(logic [23:0] s, logic [23:0] e, logic [2:0] en);
        write_reg(CFG_START_RADIUS, s);
        write_reg(CFG_END_RADIUS, e);
        write_reg(CFG_DIFFUSE, 24'($urandom));
        write_reg(CFG_REFLECT, 24'($urandom));
        write_reg(CFG_TRANSPARENT, 24'($urandom));
        write_reg(CFG_ENABLES, {21'd0, en});
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [CW-1:0] rand_coord(logic [23:0] radius);
        int unsigned span;
        int          v;
        span = (radius == 0) ? 1 : radius;
        if ($urandom_range(0, 9) == 0) return CW'($urandom);
        v = int'($urandom_range(0, span));
        return CW'(($urandom_range(0, 1) != 0) ? v : -v);
    endfunction

    // Extremes of the coordinates and colors under reset settings, then region edges and degenerate radii.
    task automatic test_directed_extremes;
        logic signed [CW-1:0] extreme [5];
        extreme = '{24'sh800000, 24'sh7FFFFF, 24'sh0, 24'shFFFFFF, 24'sh000001};
        for (int i = 0; i < 5; i++)
            send_hit(extreme[i], extreme[(i + 1) % 5], extreme[(i + 2) % 5],
                     24'hFFFFFF, 24'h000000, 24'hA5A55A, 0);
        drain();
        configure(24'h008000, 24'h018000, 3'b111);
        // Inside, on the inner radius, between, on the outer radius, outside.
        send_hit(0, 0, 0, 24'h123456, 24'hFFFFFF, 24'h0, 0);
        send_hit(24'sh008000, 0, 0, 24'h123456, 24'hFFFFFF, 24'h0, 0);
        send_hit(0, 24'sh010000, 0, 24'hFFFFFF, 24'h000000, 24'h808080, 1);
        send_hit(0, 0, -24'sh018000, 24'h123456, 24'hFFFFFF, 24'h0, 0);
        send_hit(24'sh800000, 24'sh800000, 24'sh800000, 24'h1, 24'h2, 24'h3, 2);
        drain();
        // Equal and inverted radii never divide.
        configure(24'h010000, 24'h010000, 3'b101);
        send_hit(24'sh010000, 0, 0, 24'h111111, 24'h222222, 24'h333333, 0);
        send_hit(24'sh010001, 0, 0, 24'h111111, 24'h222222, 24'h333333, 0);
        drain();
        configure(24'hFFFFFF, 24'h000000, 3'b010);
        send_hit(24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 24'hABCDEF, 24'h0, 24'h1, 0);
        send_hit(-24'sh100000, 0, 0, 24'hABCDEF, 24'h0, 24'h1, 0);
        drain();
    endtask

    // Random hits around the radii with random gaps and stalls.
    task automatic test_random_hits(int count);
        for (int i = 0; i < count; i++)
            send_hit(rand_coord(shadow_end), rand_coord(shadow_end), rand_coord(shadow_end),
                     24'($urandom), 24'($urandom), 24'($urandom),
                     ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18));
    endtask

    // Long receiver hold-off while hits keep coming, so the input stalls.
    task automatic test_backpressure;
        hold_off_cycles = 200;
        for (int i = 0; i < 60; i++)
            send_hit(rand_coord(shadow_end), rand_coord(shadow_end), rand_coord(shadow_end),
                     24'($urandom), 24'($urandom), 24'($urandom), 0);
        drain();
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_pos_x = '0;
        i_pos_y = '0;
        i_pos_z = '0;
        i_in_diffuse = '0;
        i_in_reflect = '0;
        i_in_transparent = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_START_RADIUS;
        i_cfg_data = '0;
        error_count = 0;
        cycle_count = 0;
        hold_off_cycles = 0;
        random_stalls = 1'b1;
        shadow_start = 24'd0;
        shadow_end = 24'd65536;
        shadow_target = '{24'd0, 24'd0, 24'd0};
        shadow_enables = 3'b001;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_directed_extremes();
        configure(24'h004000, 24'h030000, 3'b111);
        random_stalls = 1'b0;
        test_random_hits(60);
        drain();
        random_stalls = 1'b1;
        test_random_hits(100);
        drain();
        configure(24'h000000, 24'hFFFFFF, 3'b011);
        test_random_hits(100);
        drain();
        configure(24'h100000, 24'h180000, 3'b110);
        test_backpressure();
        configure(24'h020000, 24'h020001, 3'b100);
        test_random_hits(100);
        drain();
        configure(24'h000001, 24'h100000, 3'b111);
        test_random_hits(80);
        drain();

        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

FILE: radial_gradient_color_blend_unit.f
+incdir+design
design/rgcb_pkg.sv
design/rgcb_sqrt.sv
design/rgcb_div.sv
design/radial_gradient_color_blend_unit.sv
bench/radial_gradient_color_blend_unit_tb.sv
